// ===== rtl/websocket_frame_receiver_macros.svh =====
// Assertion macros used by the checker file of the frame receiver.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define WSFR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsfr assertion failed");

// Next-cycle implication, disabled while reset is high.
`define WSFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsfr assertion failed");

`endif

// ===== rtl/wsfr_pkg.sv =====
// Shared types and constants of the WebSocket frame receiver.
// Depends on nothing; used by the interfaces, all modules and the checker.
package wsfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned OPCODE_W = 4;
  localparam int unsigned LEN_W    = 21;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [CNT_W-1:0] LAST_CNT_LEN16 = 3'd1;
  localparam logic [CNT_W-1:0] LAST_CNT_LEN64 = 3'd7;
  localparam logic [CNT_W-1:0] LAST_CNT_MASK  = 3'd3;

  localparam logic [0:0]       REG_MAX_PAYLOAD   = 1'b0;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 21'd16384;

  // Byte held in the input register, handed to the parser.
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
  } stage_t;

endpackage

// ===== rtl/wsfr_if.sv =====
// Valid/ready channel interfaces for received bytes and parse results.
// Depends on wsfr_pkg for field widths.
interface wsfr_byte_if import wsfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface wsfr_result_if import wsfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   result_kind;
  logic [BYTE_W-1:0]   payload_byte;
  logic [OPCODE_W-1:0] frame_opcode;
  logic                last_of_frame;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_opcode, output last_of_frame, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input frame_opcode, input last_of_frame, output ready);
endinterface

// ===== rtl/wsfr_apb_regs.sv =====
// APB register file holding the maximum payload length.
// Depends on wsfr_pkg.
module wsfr_apb_regs import wsfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  max_payload
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      max_payload <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_PAYLOAD) begin
      prdata = {{(APB_DW-LEN_W){1'b0}}, max_payload};
    end
  end

endmodule

// ===== rtl/wsfr_parser.sv =====
// Frame header parser, unmasking logic and result register.
// Depends on wsfr_pkg and the result channel interface.
module wsfr_parser import wsfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] max_payload,
  input  stage_t           stage,
  output logic             take,
  wsfr_result_if.source    result
);

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_LEN16   = 3'd2,
    PH_LEN64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  phase_t              phase, phase_next;
  logic [OPCODE_W-1:0] frame_kind, frame_kind_next;
  logic                mask_present, mask_present_next;
  logic [CNT_W-1:0]    hdr_cnt, hdr_cnt_next;
  // Length is kept as its low bits plus a flag for any set bit above them.
  logic [LEN_W-1:0]    len_lo, len_lo_next;
  logic                len_hi, len_hi_next;
  logic [KEY_W-1:0]    mask_key, mask_key_next;
  logic [LEN_W-1:0]    bytes_left, bytes_left_next;
  logic [1:0]          key_pos, key_pos_next;
  logic                halted, halted_next;

  logic                after_len, fin;
  logic [LEN_W-1:0]    fin_lo;
  logic                fin_hi;
  logic [BYTE_W-1:0]   key_byte;
  logic                res_ok;
  logic [KIND_W-1:0]   res_kind;
  logic [BYTE_W-1:0]   res_byte;
  logic                res_last;
  logic                out_free;

  assign out_free = !result.valid || result.ready;
  assign take     = stage.vld && out_free;

  always_comb begin
    case (key_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      2'd3:    key_byte = mask_key[7:0];
      default: key_byte = '0;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    frame_kind_next   = frame_kind;
    mask_present_next = mask_present;
    hdr_cnt_next      = hdr_cnt;
    len_lo_next       = len_lo;
    len_hi_next       = len_hi;
    mask_key_next     = mask_key;
    bytes_left_next   = bytes_left;
    key_pos_next      = key_pos;
    halted_next       = halted;
    after_len         = 1'b0;
    fin               = 1'b0;
    fin_lo            = len_lo;
    fin_hi            = len_hi;
    res_ok            = 1'b0;
    res_kind          = KIND_PAYLOAD;
    res_byte          = '0;
    res_last          = 1'b0;

    if (!halted) begin
      case (phase)
        PH_FIRST: begin
          frame_kind_next = stage.data[OPCODE_W-1:0];
          phase_next      = PH_SECOND;
        end
        PH_SECOND: begin
          mask_present_next = stage.data[7];
          hdr_cnt_next      = '0;
          len_hi_next       = 1'b0;
          if (stage.data[6:0] == LEN_CODE_64) begin
            len_lo_next = '0;
            phase_next  = PH_LEN64;
          end else if (stage.data[6:0] == LEN_CODE_16) begin
            len_lo_next = '0;
            phase_next  = PH_LEN16;
          end else begin
            len_lo_next = {{(LEN_W-7){1'b0}}, stage.data[6:0]};
            after_len   = 1'b1;
          end
        end
        PH_LEN16, PH_LEN64: begin
          len_lo_next = {len_lo[LEN_W-BYTE_W-1:0], stage.data};
          len_hi_next = len_hi || (|len_lo[LEN_W-1:LEN_W-BYTE_W]);
          if (hdr_cnt == ((phase == PH_LEN16) ? LAST_CNT_LEN16 : LAST_CNT_LEN64)) begin
            after_len = 1'b1;
          end else begin
            hdr_cnt_next = hdr_cnt + 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[KEY_W-BYTE_W-1:0], stage.data};
          if (hdr_cnt == LAST_CNT_MASK) begin
            fin = 1'b1;
          end else begin
            hdr_cnt_next = hdr_cnt + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          key_pos_next = key_pos + 2'd1;
          if (bytes_left != '0) begin
            bytes_left_next = bytes_left - {{(LEN_W-1){1'b0}}, 1'b1};
          end
          res_ok   = 1'b1;
          res_byte = mask_present ? (stage.data ^ key_byte) : stage.data;
          res_last = (bytes_left[LEN_W-1:1] == '0);
          if (res_last) begin
            phase_next = PH_FIRST;
          end
        end
        default: begin
          phase_next = PH_FIRST;
        end
      endcase

      fin_lo = len_lo_next;
      fin_hi = len_hi_next;

      if (after_len) begin
        if (mask_present_next) begin
          phase_next    = PH_MASK;
          hdr_cnt_next  = '0;
          mask_key_next = '0;
        end else begin
          fin = 1'b1;
        end
      end

      // The byte that completes the header decides between error, empty and payload.
      if (fin) begin
        if (fin_hi || (fin_lo > max_payload)) begin
          halted_next = 1'b1;
          phase_next  = PH_FIRST;
          res_ok      = 1'b1;
          res_kind    = KIND_ERROR;
          res_last    = 1'b1;
        end else if (fin_lo == '0) begin
          phase_next = PH_FIRST;
          res_ok     = 1'b1;
          res_kind   = KIND_EMPTY;
          res_last   = 1'b1;
        end else begin
          bytes_left_next = fin_lo;
          key_pos_next    = '0;
          phase_next      = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FIRST;
      frame_kind   <= '0;
      mask_present <= 1'b0;
      hdr_cnt      <= '0;
      len_lo       <= '0;
      len_hi       <= 1'b0;
      mask_key     <= '0;
      bytes_left   <= '0;
      key_pos      <= '0;
      halted       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        frame_kind   <= frame_kind_next;
        mask_present <= mask_present_next;
        hdr_cnt      <= hdr_cnt_next;
        len_lo       <= len_lo_next;
        len_hi       <= len_hi_next;
        mask_key     <= mask_key_next;
        bytes_left   <= bytes_left_next;
        key_pos      <= key_pos_next;
        halted       <= halted_next;
      end
      if (out_free) begin
        result.valid <= take && res_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_ok) begin
      result.result_kind   <= res_kind;
      result.payload_byte  <= res_byte;
      result.frame_opcode  <= frame_kind;
      result.last_of_frame <= res_last;
    end
  end

endmodule

// ===== rtl/websocket_frame_receiver.sv =====
// Top level of the WebSocket frame receiver: input register, parser, registers.
// Depends on wsfr_pkg, wsfr_if, wsfr_apb_regs and wsfr_parser.
//
//   Port    Kind           Carries
//   rx      byte sink      data_byte, one received byte per transfer
//   result  result source  result_kind, payload_byte, frame_opcode, last_of_frame
//   APB     register port  max_payload at byte address 0
//
// One byte per cycle is sustained while result is ready; a byte's result passes
// through the input register into the result register, which drives result.
// Non-final header bytes and bytes after an oversize error produce no result.
// rst is synchronous and clears the parser state and both valid flags.
// A stall on result holds the result register and, one stage back, the input register.
module websocket_frame_receiver import wsfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  wsfr_byte_if.sink         rx,
  wsfr_result_if.source     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  stage_t           stage;
  logic             take;
  logic [LEN_W-1:0] max_payload;

  assign rx.ready = !stage.vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.vld <= 1'b0;
    end else if (rx.ready) begin
      stage.vld <= rx.valid;
      if (rx.valid) begin
        stage.data <= rx.data_byte;
      end
    end
  end

  wsfr_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  wsfr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .max_payload (max_payload),
    .stage       (stage),
    .take        (take),
    .result      (result)
  );

endmodule

// ===== rtl/wsfr_checker.sv =====
// Port-level checks of the frame receiver, bound to the top level.
// Depends on wsfr_pkg and websocket_frame_receiver_macros.svh.
`include "websocket_frame_receiver_macros.svh"

module wsfr_checker import wsfr_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input logic [KIND_W-1:0]   res_kind,
  input logic [BYTE_W-1:0]   res_byte,
  input logic [OPCODE_W-1:0] res_opcode,
  input logic                res_last
);

  logic err_seen;

  // Once an error has been transferred, the receiver stays silent until reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
    end else if (res_valid && res_ready && (res_kind == KIND_ERROR)) begin
      err_seen <= 1'b1;
    end
  end

  `WSFR_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready,
    res_valid && $stable(res_kind) && $stable(res_byte) && $stable(res_opcode) && $stable(res_last))
  `WSFR_ASSERT_IMP(a_kind_legal, clk, rst, res_valid,
    (res_kind == KIND_PAYLOAD) || (res_kind == KIND_EMPTY) || (res_kind == KIND_ERROR))
  `WSFR_ASSERT_IMP(a_non_payload, clk, rst, res_valid && (res_kind != KIND_PAYLOAD),
    res_last && (res_byte == '0))
  `WSFR_ASSERT_IMP(a_silent_after_err, clk, rst, err_seen, !res_valid)

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_kind   (result.result_kind),
  .res_byte   (result.payload_byte),
  .res_opcode (result.frame_opcode),
  .res_last   (result.last_of_frame)
);

// ===== tb/sv/websocket_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// Testbench of websocket_frame_receiver: random and directed WebSocket frames in,
// unmasked payload, empty-frame and oversize results checked against a predictor.
// Depends on wsfr_pkg, wsfr_if and the RTL of the frame receiver.
module websocket_frame_receiver_tb;
  import wsfr_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_SLACK    = 6;
  localparam int END_SLACK      = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_CAP       = 400;
  localparam logic [APB_AW-1:0] MAX_PAYLOAD_ADDR = APB_AW'(4 * REG_MAX_PAYLOAD);

  typedef enum logic [2:0] {
    AWAIT_OPCODE, AWAIT_LEN7, AWAIT_LEN16, AWAIT_LEN64, AWAIT_KEY, IN_PAYLOAD
  } parse_phase_t;

  typedef enum {FORM_7, FORM_16, FORM_64} len_form_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   data;
    logic [OPCODE_W-1:0] opcode;
    logic                last;
  } parse_result_t;

  // Tracks the frame parser byte by byte and holds the results still due.
  class frame_decoder;
    logic [LEN_W-1:0]    max_len;
    parse_phase_t        phase;
    logic [OPCODE_W-1:0] opcode;
    logic                masked;
    logic [CNT_W-1:0]    count;
    logic [63:0]         length;
    logic [KEY_W-1:0]    key;
    logic [63:0]         left;
    logic [1:0]          pos;
    logic                halted;
    parse_result_t       due_results[$];
    int                  mismatch_count;

    function new();
      max_len = MAX_PAYLOAD_RESET;
      phase = AWAIT_OPCODE;
      opcode = '0;
      masked = 1'b0;
      count = '0;
      length = '0;
      key = '0;
      left = '0;
      pos = '0;
      halted = 1'b0;
      mismatch_count = 0;
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data, logic last);
      parse_result_t r;
      r.kind = kind;
      r.data = data;
      r.opcode = opcode;
      r.last = last;
      due_results.push_back(r);
    endfunction

    function void close_header();
      phase = AWAIT_OPCODE;
      if (length > 64'(max_len)) begin
        halted = 1'b1;
        push(KIND_ERROR, '0, 1'b1);
      end else if (length == 0) begin
        push(KIND_EMPTY, '0, 1'b1);
      end else begin
        left = length;
        pos = '0;
        phase = IN_PAYLOAD;
      end
    endfunction

    function void after_length();
      if (masked) begin
        phase = AWAIT_KEY;
        count = '0;
        key = '0;
      end else begin
        close_header();
      end
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] k;
      if (halted) return;
      case (phase)
        AWAIT_OPCODE: begin
          opcode = b[OPCODE_W-1:0];
          phase = AWAIT_LEN7;
        end
        AWAIT_LEN7: begin
          masked = b[7];
          length = 64'(b[6:0]);
          count = '0;
          if (b[6:0] == LEN_CODE_64) begin
            length = '0;
            phase = AWAIT_LEN64;
          end else if (b[6:0] == LEN_CODE_16) begin
            length = '0;
            phase = AWAIT_LEN16;
          end else begin
            after_length();
          end
        end
        AWAIT_LEN16, AWAIT_LEN64: begin
          length = {length[55:0], b};
          if (count == ((phase == AWAIT_LEN16) ? LAST_CNT_LEN16 : LAST_CNT_LEN64))
            after_length();
          else
            count = count + 1'b1;
        end
        AWAIT_KEY: begin
          key = {key[23:0], b};
          if (count == LAST_CNT_MASK)
            close_header();
          else
            count = count + 1'b1;
        end
        IN_PAYLOAD: begin
          // The first key byte is the most significant one.
          k = masked ? key[31 - 8 * pos -: 8] : '0;
          pos = pos + 1'b1;
          if (left > 0) left = left - 1;
          if (left == 0) phase = AWAIT_OPCODE;
          push(KIND_PAYLOAD, b ^ k, left == 0);
        end
        default: phase = AWAIT_OPCODE;
      endcase
    endfunction

    function void match_result(parse_result_t got);
      parse_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: result_kind %0d payload_byte %0d", got.kind, got.data);
        mismatch_count++;
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("result_kind expected %0d actual %0d", want.kind, got.kind);
        mismatch_count++;
      end
      if (got.data !== want.data) begin
        $error("payload_byte expected %0d actual %0d", want.data, got.data);
        mismatch_count++;
      end
      if (got.opcode !== want.opcode) begin
        $error("frame_opcode expected %0d actual %0d", want.opcode, got.opcode);
        mismatch_count++;
      end
      if (got.last !== want.last) begin
        $error("last_of_frame expected %0d actual %0d", want.last, got.last);
        mismatch_count++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  wsfr_byte_if   rx_ch();
  wsfr_result_if res_ch();

  frame_decoder decoder;
  int           sender_idle_pct;
  int           receiver_idle_pct;
  int           bytes_sent;
  int           hold_left;
  bit           hold_request;
  int           quiet_cycles;

  websocket_frame_receiver DUT (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Result side: check each transfer, then pick ready for the next edge.
  always @(posedge clk) begin
    parse_result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.kind = res_ch.result_kind;
      got.data = res_ch.payload_byte;
      got.opcode = res_ch.frame_opcode;
      got.last = res_ch.last_of_frame;
      decoder.match_result(got);
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.data_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    decoder.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [BYTE_W-1:0] first, input logic [63:0] len,
                             input len_form_t form, input logic masked,
                             input logic [KEY_W-1:0] key);
    logic [6:0] code;
    code = (form == FORM_7) ? len[6:0] : (form == FORM_16) ? LEN_CODE_16 : LEN_CODE_64;
    send_byte(first);
    send_byte({masked, code});
    if (form == FORM_16)
      for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
    if (form == FORM_64)
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] first, input logic [63:0] len,
                            input len_form_t form, input logic masked,
                            input logic [KEY_W-1:0] key);
    send_header(first, len, form, masked, key);
    for (longint n = 0; n < len; n++) send_byte(BYTE_W'($urandom_range(255)));
  endtask

  // Lengths stay within the current limit; most are short, a few are long.
  task automatic send_random_frame();
    int unsigned top;
    int unsigned len;
    int unsigned r;
    len_form_t   form;
    top = (decoder.max_len > LONG_CAP) ? LONG_CAP : decoder.max_len;
    r = $urandom_range(99);
    if (top == 0 || r < 10)
      len = 0;
    else if (r < 13)
      len = (top < 125) ? top : 125;
    else if (r < 16)
      len = $urandom_range(top, 1);
    else
      len = $urandom_range((top < 24) ? top : 24, 1);
    r = $urandom_range(99);
    if (len <= 125)
      form = (r < 70) ? FORM_7 : (r < 85) ? FORM_16 : FORM_64;
    else
      form = (r < 80) ? FORM_16 : FORM_64;
    send_frame(BYTE_W'($urandom_range(255)), 64'(len), form, 1'($urandom_range(1)),
               KEY_W'($urandom));
  endtask

  task automatic drain();
    while (decoder.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Registers are only written once the parser has nothing in flight.
  task automatic set_max_payload(input logic [LEN_W-1:0] v);
    rx_ch.valid <= 1'b0;
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_PAYLOAD_ADDR;
    pwdata <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    decoder.max_len = v;
  endtask

  initial begin
    logic [63:0] huge;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_ch.valid = 1'b0;
    rx_ch.data_byte = '0;
    res_ch.ready = 1'b0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    bytes_sent = 0;
    hold_left = 0;
    hold_request = 1'b0;
    quiet_cycles = 0;
    decoder = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset limit: empty frame with FIN set, a masked short
    // frame with reserved bits set, then 16-bit and masked 64-bit length encodings.
    send_frame(8'h8F, 64'd0, FORM_7, 1'b0, '0);
    send_frame(8'h70, 64'd3, FORM_7, 1'b1, 32'hFF00A55A);
    send_frame(8'h01, 64'd1, FORM_16, 1'b0, '0);
    send_frame(8'hF2, 64'd1, FORM_64, 1'b1, 32'h01234567);

    set_max_payload('1);
    sender_idle_pct = 16;
    receiver_idle_pct = 76;
    while (bytes_sent < 350) send_random_frame();

    // With a zero limit only empty frames get through.
    set_max_payload('0);
    sender_idle_pct = 76;
    receiver_idle_pct = 16;
    repeat (20) send_random_frame();
    set_max_payload(LEN_W'($urandom_range(30, 1)));
    while (bytes_sent < 700) send_random_frame();

    set_max_payload(LEN_W'(1048576));
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    hold_request = 1'b1;
    while (bytes_sent < 1050) send_random_frame();

    // An oversize 64-bit length with its top bit set halts the parser for good,
    // so it comes last, followed by bytes that must be ignored.
    huge = {32'($urandom), 32'($urandom)};
    huge[63] = 1'b1;
    send_header(BYTE_W'($urandom_range(255)), huge, FORM_64, 1'($urandom_range(1)),
                KEY_W'($urandom));
    repeat (24) send_byte(BYTE_W'($urandom_range(255)));
    rx_ch.valid <= 1'b0;

    drain();
    repeat (END_SLACK) @(posedge clk);
    if (decoder.mismatch_count == 0 && decoder.due_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wsfr_pkg.sv
rtl/wsfr_if.sv
rtl/wsfr_apb_regs.sv
rtl/wsfr_parser.sv
rtl/websocket_frame_receiver.sv
rtl/wsfr_checker.sv
tb/sv/websocket_frame_receiver_tb.sv
